// ----- rtl/ptpl_pkg.sv -----
`timescale 1ns / 1ps
package ptpl_pkg;

  localparam int COORD_BITS       = 24;
  localparam int MAX_VERTICES_DEF = 1024;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LEN_W  = 51;
  localparam int MAG_W  = 51;
  localparam int LO_W   = 26;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int C2_W   = 2 * MAG_W;
  localparam int KEY_W  = 68;
  localparam int ROOT_W = KEY_W / 2;
  localparam int DIST_W = 33;
  localparam int FRAC_SH = 16;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  mark;
  } vtx_t;

  typedef struct packed {
    logic             degen;
    logic [KEY_W-1:0] key;
  } edge_res_t;

  typedef enum logic [3:0] {
    T_IDLE, T_READ, T_VTX, T_E1_GO, T_E1_WAIT, T_E2_GO, T_E2_WAIT,
    T_NEXT, T_SQ_GO, T_SQ_WAIT, T_DONE
  } top_state_t;

  typedef enum logic [4:0] {
    E_IDLE, E_LEN0, E_LEN1, E_DOT0, E_DOT1, E_DOTF, E_DEC,
    E_SQ0, E_SQ1, E_SQF, E_CR0, E_CR1, E_CRF,
    E_C2A, E_C2B, E_C2C, E_C2D, E_DIVI, E_DIV, E_DONE
  } edge_state_t;

endpackage

// ----- rtl/ptpl_if.sv -----
`timescale 1ns / 1ps
interface ptpl_req_if import ptpl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         loop_last;

  modport source (output valid, req_type, pos_x, pos_y, loop_last, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, loop_last, output ready);
endinterface

interface ptpl_rsp_if import ptpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [1:0]        status;

  modport source (output valid, distance, status, input ready);
  modport sink (input valid, distance, status, output ready);
endinterface

// ----- rtl/ptpl_edge.sv -----
`timescale 1ns / 1ps
module ptpl_edge import ptpl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic                         done,
  output edge_res_t                    res
);

  edge_state_t state, state_next;

  logic signed [DIFF_W-1:0] ex, ey, vx, vy, wx, wy;
  logic                     use_end;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   acc, dot, sum, dif;
  logic [LEN_W-1:0]         len2;
  logic [MAG_W-1:0]         mag;
  logic [C2_W-1:0]          c2;
  logic [LEN_W-1:0]         rem;
  logic [KEY_W-1:0]         dq;
  logic [6:0]               cnt;
  logic [LEN_W:0]           r2;
  logic                     ge;

  assign sum = acc + (PROD_W + 1)'(prod);
  assign dif = acc - (PROD_W + 1)'(prod);
  assign r2  = {rem, dq[KEY_W-1]};
  assign ge  = r2 >= {1'b0, len2};

  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: if (start) state_next = E_LEN0;
      E_LEN0: state_next = E_LEN1;
      E_LEN1: state_next = E_DOT0;
      E_DOT0: state_next = E_DOT1;
      E_DOT1: state_next = E_DOTF;
      E_DOTF: state_next = E_DEC;
      E_DEC: begin
        if (len2 == '0) state_next = E_DONE;
        else if (dot[PROD_W] || dot > (PROD_W + 1)'(len2)) state_next = E_SQ0;
        else state_next = E_CR0;
      end
      E_SQ0:  state_next = E_SQ1;
      E_SQ1:  state_next = E_SQF;
      E_SQF:  state_next = E_DONE;
      E_CR0:  state_next = E_CR1;
      E_CR1:  state_next = E_CRF;
      E_CRF:  state_next = E_C2A;
      E_C2A:  state_next = E_C2B;
      E_C2B:  state_next = E_C2C;
      E_C2C:  state_next = E_C2D;
      E_C2D:  state_next = E_DIVI;
      E_DIVI: state_next = E_DIV;
      E_DIV:  if (cnt == 7'(KEY_W - 1)) state_next = E_DONE;
      E_DONE: state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    ma   = '0;
    mb   = '0;
    case (state)
      E_LEN0: begin ma = MUL_W'(ex); mb = MUL_W'(ex); end
      E_LEN1: begin ma = MUL_W'(ey); mb = MUL_W'(ey); end
      E_DOT0: begin ma = MUL_W'(ex); mb = MUL_W'(vx); end
      E_DOT1: begin ma = MUL_W'(ey); mb = MUL_W'(vy); end
      E_SQ0: begin
        ma = MUL_W'(use_end ? wx : vx);
        mb = MUL_W'(use_end ? wx : vx);
      end
      E_SQ1: begin
        ma = MUL_W'(use_end ? wy : vy);
        mb = MUL_W'(use_end ? wy : vy);
      end
      E_CR0: begin ma = MUL_W'(ex); mb = MUL_W'(vy); end
      E_CR1: begin ma = MUL_W'(ey); mb = MUL_W'(vx); end
      E_C2A: begin
        ma = MUL_W'({1'b0, mag[MAG_W-1:LO_W]});
        mb = MUL_W'({1'b0, mag[MAG_W-1:LO_W]});
      end
      E_C2B: begin
        ma = MUL_W'({1'b0, mag[MAG_W-1:LO_W]});
        mb = MUL_W'({1'b0, mag[LO_W-1:0]});
      end
      E_C2C: begin
        ma = MUL_W'({1'b0, mag[LO_W-1:0]});
        mb = MUL_W'({1'b0, mag[LO_W-1:0]});
      end
      E_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= E_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      E_IDLE: begin
        ex <= DIFF_W'(bx) - DIFF_W'(ax);
        ey <= DIFF_W'(by) - DIFF_W'(ay);
        vx <= DIFF_W'(px) - DIFF_W'(ax);
        vy <= DIFF_W'(py) - DIFF_W'(ay);
        wx <= DIFF_W'(px) - DIFF_W'(bx);
        wy <= DIFF_W'(py) - DIFF_W'(by);
      end
      E_LEN1, E_DOT1, E_SQ1, E_CR1: acc <= (PROD_W + 1)'(prod);
      E_DOT0: len2 <= LEN_W'(sum);
      E_DOTF: dot <= sum;
      E_DEC: begin
        use_end   <= !dot[PROD_W];
        res.degen <= (len2 == '0);
      end
      E_SQF: res.key <= KEY_W'(unsigned'(sum)) << FRAC_SH;
      E_CRF: mag <= dif[PROD_W] ? MAG_W'(-dif) : MAG_W'(dif);
      E_C2B: c2 <= C2_W'(unsigned'(prod)) << (2 * LO_W);
      E_C2C: c2 <= c2 + (C2_W'(unsigned'(prod)) << (LO_W + 1));
      E_C2D: c2 <= c2 + C2_W'(unsigned'(prod));
      E_DIVI: begin
        // numerator is c2 << 16; leading part already below len2
        rem <= LEN_W'(c2 >> (KEY_W - FRAC_SH));
        dq  <= {c2[KEY_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
        cnt <= '0;
      end
      E_DIV: begin
        rem <= ge ? LEN_W'(r2 - {1'b0, len2}) : r2[LEN_W-1:0];
        dq  <= {dq[KEY_W-2:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(KEY_W - 1)) res.key <= {dq[KEY_W-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ptpl_sqrt.sv -----
`timescale 1ns / 1ps
module ptpl_sqrt import ptpl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic              busy;
  logic [5:0]        cnt;
  logic [KEY_W-1:0]  val;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] acc;
  logic [ROOT_W+3:0] rp, trial;
  logic              ge;

  assign rp    = {rem, val[KEY_W-1:KEY_W-2]};
  assign trial = (ROOT_W + 4)'({acc, 2'b01});
  assign ge    = rp >= trial;
  assign root  = DIST_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= key;
      rem <= '0;
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      val <= val << 2;
      rem <= ge ? (ROOT_W + 2)'(rp - trial) : (ROOT_W + 2)'(rp);
      acc <= {acc[ROOT_W-2:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

// ----- rtl/point_to_polygon_loops_distance_core.sv -----
// Clear and append take effect when accepted; an append on a full store or a query on an empty
// store answers in the next cycle. A query reads one vertex per pass and runs each edge
// through the shared edge unit (the 68-step key divider is its longest path), then takes
// the square root of the smallest key unless an edge was degenerate.
// Synchronous reset empties the store; vertex memory contents are not cleared.
`timescale 1ns / 1ps
module point_to_polygon_loops_distance_core import ptpl_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input logic         clk,
  input logic         rst,
  ptpl_req_if.sink    req,
  ptpl_rsp_if.source  rsp
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  top_state_t state, state_next;

  vtx_t mem [MAX_VERTICES];
  vtx_t rd;

  logic [CW-1:0] count, k;
  logic signed [COORD_BITS-1:0] qx, qy;
  vtx_t cur, prev, first;
  logic fresh, last;

  logic accept, out_free, full, is_end;
  logic edge_start, edge_done, sq_start, sq_done;
  logic signed [COORD_BITS-1:0] eax, eay, ebx, eby;
  edge_res_t eres;
  logic [DIST_W-1:0] root;

  logic have, degen_any;
  logic [KEY_W-1:0] best;
  logic [DIST_W-1:0] res_dist;
  logic [1:0] res_status;

  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign full     = (count == CW'(MAX_VERTICES));
  assign is_end   = ((k + CW'(1)) == count);

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: if (accept && req.req_type == REQ_QUERY && count != '0) state_next = T_READ;
      T_READ: state_next = T_VTX;
      T_VTX: begin
        if (!fresh) state_next = T_E1_GO;
        else if (rd.mark || is_end) state_next = T_E2_GO;
        else state_next = T_NEXT;
      end
      T_E1_GO: state_next = T_E1_WAIT;
      T_E1_WAIT: if (edge_done) state_next = last ? T_E2_GO : T_NEXT;
      T_E2_GO: state_next = T_E2_WAIT;
      T_E2_WAIT: if (edge_done) state_next = T_NEXT;
      T_NEXT: begin
        if (!is_end) state_next = T_READ;
        else if (degen_any || !have) state_next = T_DONE;
        else state_next = T_SQ_GO;
      end
      T_SQ_GO: state_next = T_SQ_WAIT;
      T_SQ_WAIT: if (sq_done) state_next = T_DONE;
      T_DONE: if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    edge_start = 1'b0;
    sq_start   = 1'b0;
    eax = cur.x;
    eay = cur.y;
    ebx = first.x;
    eby = first.y;
    case (state)
      T_IDLE: req.ready = out_free;
      T_E1_GO: begin
        edge_start = 1'b1;
        eax = prev.x;
        eay = prev.y;
        ebx = cur.x;
        eby = cur.y;
      end
      T_E2_GO: edge_start = 1'b1;
      T_SQ_GO: sq_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_APPEND && !full)
      mem[count[AW-1:0]] <= '{x: req.pos_x, y: req.pos_y, mark: req.loop_last};
    rd <= mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (req.req_type == REQ_CLEAR) count <= '0;
      else if (req.req_type == REQ_APPEND && !full) count <= count + CW'(1);
    end
  end

  // edge walk
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == T_IDLE && accept) begin
      k <= '0;
    end else if (state == T_NEXT && !is_end) begin
      k <= k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        qx        <= req.pos_x;
        qy        <= req.pos_y;
        fresh     <= 1'b1;
        have      <= 1'b0;
        degen_any <= 1'b0;
      end
      T_VTX: begin
        cur  <= rd;
        last <= rd.mark || is_end;
        if (fresh) first <= rd;
      end
      T_NEXT: begin
        prev  <= cur;
        fresh <= last;
      end
      default: ;
    endcase
    if (edge_done) begin
      if (eres.degen) begin
        degen_any <= 1'b1;
      end else if (!have || eres.key < best) begin
        best <= eres.key;
        have <= 1'b1;
      end
    end
    if (state == T_NEXT && is_end) begin
      res_dist   <= '0;
      res_status <= ST_DEGEN;
    end else if (sq_done) begin
      res_dist   <= root;
      res_status <= ST_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == T_IDLE && accept && req.req_type == REQ_APPEND && full) begin
      rsp.valid <= 1'b1;
    end else if (state == T_IDLE && accept && req.req_type == REQ_QUERY && count == '0) begin
      rsp.valid <= 1'b1;
    end else if (state == T_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_IDLE && accept && req.req_type == REQ_APPEND && full) begin
      rsp.distance <= '0;
      rsp.status   <= ST_FULL;
    end else if (state == T_IDLE && accept && req.req_type == REQ_QUERY && count == '0) begin
      rsp.distance <= '0;
      rsp.status   <= ST_EMPTY;
    end else if (state == T_DONE && out_free) begin
      rsp.distance <= res_dist;
      rsp.status   <= res_status;
    end
  end

  ptpl_edge u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (edge_start),
    .ax    (eax),
    .ay    (eay),
    .bx    (ebx),
    .by    (eby),
    .px    (qx),
    .py    (qy),
    .done  (edge_done),
    .res   (eres)
  );

  ptpl_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .key   (best),
    .done  (sq_done),
    .root  (root)
  );

endmodule

// ----- test/ptpl_dist_checker.sv -----
`timescale 1ns / 1ps
module ptpl_dist_checker import ptpl_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst,
  ptpl_req_if  req,
  ptpl_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } answer_t;

  answer_t answers_q[$];

  logic signed [COORD_BITS-1:0] store_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] store_y [MAX_VERTICES];
  logic                         store_mark [MAX_VERTICES];
  int unsigned n_stored;
  int unsigned loop_head;

  function automatic answer_t nearest_edge(logic signed [COORD_BITS-1:0] px,
                                           logic signed [COORD_BITS-1:0] py);
    answer_t a;
    wide_t x0, y0, x1, y1, ex, ey, vx, vy, len2, dot, c, key, best, r, t;
    int unsigned first, nxt;
    logic degen, have, wrap;
    a = '0;
    degen = 1'b0;
    have = 1'b0;
    first = 0;
    best = '0;
    for (int unsigned k = 0; k < n_stored; k++) begin
      wrap = store_mark[k] || (k + 1 == n_stored);
      nxt = wrap ? first : k + 1;
      if (store_mark[k]) first = k + 1;
      x0 = store_x[k];   y0 = store_y[k];
      x1 = store_x[nxt]; y1 = store_y[nxt];
      ex = x1 - x0; ey = y1 - y0;
      vx = wide_t'(px) - x0; vy = wide_t'(py) - y0;
      len2 = ex * ex + ey * ey;
      if (len2 == 0) begin
        degen = 1'b1;
        continue;
      end
      dot = ex * vx + ey * vy;
      if (dot < 0) begin
        key = (vx * vx + vy * vy) * 65536;
      end else if (dot > len2) begin
        key = ((wide_t'(px) - x1) * (wide_t'(px) - x1) +
               (wide_t'(py) - y1) * (wide_t'(py) - y1)) * 65536;
      end else begin
        c = ex * vy - ey * vx;
        key = (c * c * 65536) / len2;
      end
      if (!have || key < best) begin
        best = key;
        have = 1'b1;
      end
    end
    if (degen || !have) begin
      a.status = ST_DEGEN;
      return a;
    end
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= best) r = t;
    end
    if (r > wide_t'((64'd1 << DIST_W) - 1)) r = wide_t'((64'd1 << DIST_W) - 1);
    a.distance = r[DIST_W-1:0];
    a.status = ST_OK;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t a, want;
    if (rst) begin
      n_stored = 0;
      loop_head = 0;
      answers_q.delete();
      errors = 0;
    end else begin
      if (req.valid && req.ready) begin
        a = '0;
        case (req.req_type)
          REQ_CLEAR: begin
            n_stored = 0;
            loop_head = 0;
          end
          REQ_APPEND: begin
            if (n_stored >= MAX_VERTICES) begin
              a.status = ST_FULL;
              answers_q.push_back(a);
            end else begin
              store_x[n_stored] = req.pos_x;
              store_y[n_stored] = req.pos_y;
              store_mark[n_stored] = req.loop_last;
              n_stored++;
              if (req.loop_last) loop_head = n_stored;
            end
          end
          REQ_QUERY: begin
            if (n_stored == 0) begin
              a.status = ST_EMPTY;
              answers_q.push_back(a);
            end else begin
              answers_q.push_back(nearest_edge(req.pos_x, req.pos_y));
            end
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (answers_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: distance %0d status %0d", rsp.distance, rsp.status);
        end else begin
          want = answers_q.pop_front();
          if (rsp.distance !== want.distance || rsp.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected distance %0d status %0d, got distance %0d status %0d",
                       want.distance, want.status, rsp.distance, rsp.status);
          end
        end
      end
    end
    pending = answers_q.size();
  end

endmodule

// ----- test/tb_point_to_polygon_loops_distance_core.sv -----
`timescale 1ns / 1ps
module tb_point_to_polygon_loops_distance_core;
  import ptpl_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  logic quiet;
  int   n_held;
  int   rand_items;
  int   hold;

  ptpl_req_if req_ch ();
  ptpl_rsp_if rsp_ch ();

  point_to_polygon_loops_distance_core #(.MAX_VERTICES(NV)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  ptpl_dist_checker #(.MAX_VERTICES(NV)) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      hold = $urandom_range(1, 13) - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!quiet) hold = $urandom_range(0, 20);
    end
  end

  task automatic send(input logic [1:0] kind, input logic signed [COORD_BITS-1:0] x,
                      input logic signed [COORD_BITS-1:0] y, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.pos_x     <= x;
    req_ch.pos_y     <= y;
    req_ch.loop_last <= last;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_CLEAR) n_held = 0;
    else if (kind == REQ_APPEND && n_held < NV) n_held++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode);
    case (mode)
      0: return COORD_BITS'($signed($urandom_range(0, 128)) - 64);
      1: return COORD_BITS'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(COORD_BITS-1){1'b0}}};
          1: return {1'b0, {(COORD_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return COORD_BITS'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  initial begin
    logic signed [COORD_BITS-1:0] lo, hi, x, y, lx, ly;
    int mode, loops, verts;
    rst = 1'b1;
    quiet = 1'b0;
    n_held = 0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_CLEAR;
    req_ch.pos_x <= '0;
    req_ch.pos_y <= '0;
    req_ch.loop_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    lo = {1'b1, {(COORD_BITS-1){1'b0}}};
    hi = {1'b0, {(COORD_BITS-1){1'b1}}};
    // directed corners
    send(REQ_QUERY, 0, 0, 0);            // empty store
    send(REQ_APPEND, 5, 5, 1);           // one-vertex loop
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_CLEAR, hi, lo, 1);
    send(REQ_APPEND, lo, lo, 0);
    send(REQ_APPEND, hi, lo, 0);
    send(REQ_APPEND, hi, hi, 1);
    send(REQ_QUERY, lo, hi, 0);
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_QUERY, hi, hi, 0);
    send(REQ_QUERY, lo, lo, 0);
    send(2'd3, hi, hi, 1);               // unused code, ignored
    send(REQ_APPEND, 10, 10, 0);         // open loop, closed at query time
    send(REQ_APPEND, 20, 10, 0);
    send(REQ_QUERY, 15, 30, 0);
    send(REQ_QUERY, -40, 10, 0);
    send(REQ_APPEND, 20, 10, 0);         // repeated vertex, zero-length edge
    send(REQ_QUERY, 15, 30, 0);
    send(REQ_CLEAR, 0, 0, 0);
    send(REQ_APPEND, 0, 0, 0);
    send(REQ_APPEND, 0, 100, 1);         // two-vertex loop
    send(REQ_QUERY, 50, 50, 0);
    send(REQ_CLEAR, 0, 0, 0);

    rand_items = 0;
    while (rand_items < 520) begin
      if (rand_items > 440) quiet = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        if (n_held > 12 || $urandom_range(0, 2) == 0) begin
          send(REQ_CLEAR, pick_coord(1), pick_coord(1), 1'($urandom));
          rand_items++;
        end
        mode = $urandom_range(0, 3);
        loops = $urandom_range(1, 2);
        for (int l = 0; l < loops; l++) begin
          verts = $urandom_range(1, 5);
          x = pick_coord(mode);
          y = pick_coord(mode);
          for (int v = 0; v < verts; v++) begin
            if ($urandom_range(0, 9) != 0) begin
              x = pick_coord(mode);
              y = pick_coord(mode);
            end
            lx = x; ly = y;
            send(REQ_APPEND, x, y, (v == verts - 1) && ($urandom_range(0, 4) != 0));
            rand_items++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) begin
            x = lx + COORD_BITS'($signed($urandom_range(0, 40)) - 20);
            y = ly + COORD_BITS'($signed($urandom_range(0, 40)) - 20);
          end else begin
            x = pick_coord($urandom_range(0, 3));
            y = pick_coord($urandom_range(0, 3));
          end
          send(REQ_QUERY, x, y, 1'($urandom));
          rand_items++;
        end
      end else begin
        mode = $urandom_range(0, 3);
        if (n_held > 14) mode = REQ_CLEAR;
        send(2'(mode), pick_coord(1), pick_coord(1), 1'($urandom));
        if (mode != 3) rand_items++;
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
